// File: src/lcd_mode_timing_sequencer_macros.svh
// Assertion macros shared by the scanline timing sequencer RTL.
`ifndef LCD_MODE_TIMING_SEQUENCER_MACROS_SVH
`define LCD_MODE_TIMING_SEQUENCER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define LMTS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define LMTS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// File: src/lcdmt_pkg.sv
// Types and constants of the scanline timing sequencer.
package lcdmt_pkg;

	localparam int DOT_W  = 9;
	localparam int LINE_W = 8;

	localparam logic [DOT_W-1:0]  DOTS_HBLANK   = 9'd204;
	localparam logic [DOT_W-1:0]  DOTS_LINE     = 9'd456;
	localparam logic [DOT_W-1:0]  DOTS_OAM      = 9'd80;
	localparam logic [DOT_W-1:0]  DOTS_TRANSFER = 9'd172;
	localparam logic [DOT_W-1:0]  STEP_NORMAL   = 9'd4;
	localparam logic [DOT_W-1:0]  STEP_DOUBLE   = 9'd2;
	localparam logic [LINE_W-1:0] LAST_VISIBLE  = 8'd143;
	localparam logic [LINE_W-1:0] LAST_LINE     = 8'd153;

	typedef enum logic [1:0] {
		MODE_HBLANK = 2'd0,
		MODE_VBLANK = 2'd1,
		MODE_OAM    = 2'd2,
		MODE_XFER   = 2'd3
	} lcd_mode_t;

	typedef enum logic [2:0] {
		REG_LINE_COMPARE   = 3'd0,
		REG_IRQ_COINC      = 3'd1,
		REG_IRQ_HBLANK     = 3'd2,
		REG_IRQ_VBLANK     = 3'd3,
		REG_IRQ_OAM        = 3'd4,
		REG_DOUBLE_SPEED   = 3'd5
	} cfg_reg_t;

	typedef enum logic {
		ITEM_TICK   = 1'b0,
		ITEM_TOGGLE = 1'b1
	} item_kind_t;

endpackage

// File: src/lcd_mode_timing_sequencer.sv
// Top level of the scanline mode timing sequencer.
//
// Channel | Direction | Handshake           | Payload
// --------+-----------+---------------------+--------------------------------------
// cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
// in      | in        | in_valid/in_ready   | mode, lcd_on
// out     | out       | out_valid/out_ready | lcd_mode, current_line, coincidence,
//         |           |                     | vblank_irq, stat_irq, line_done, frame_done
//
// The state update is one add and compare on the dot counter,
// and its result lands in the output register on the edge that takes the transfer.
// One item per cycle is sustained; in_ready drops only while a result waits in the output
// register and out_ready is low. Configuration writes are taken in every cycle.
// Reset clears the timing state, the configuration registers and out_valid, and leaves the display off.
`include "lcd_mode_timing_sequencer_macros.svh"

module lcd_mode_timing_sequencer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [2:0]                  cfg_index,
	input  logic [7:0]                  cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        mode,
	input  logic                        lcd_on,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  lcd_mode,
	output logic [lcdmt_pkg::LINE_W-1:0] current_line,
	output logic                        coincidence,
	output logic                        vblank_irq,
	output logic                        stat_irq,
	output logic                        line_done,
	output logic                        frame_done
);
	import lcdmt_pkg::*;

	logic [LINE_W-1:0] line_compare_q;
	logic              irq_coinc_q;
	logic              irq_hblank_q;
	logic              irq_vblank_q;
	logic              irq_oam_q;
	logic              double_speed_q;

	logic [DOT_W-1:0]  dot_q;
	lcd_mode_t         mode_q;
	logic [LINE_W-1:0] line_q;
	logic              coin_q;
	logic              enabled_q;

	logic [DOT_W-1:0]  dot_sum;
	logic [DOT_W-1:0]  dot_nxt;
	lcd_mode_t         mode_nxt;
	logic [LINE_W-1:0] line_nxt;
	logic              coin_nxt;
	logic              enabled_nxt;
	logic              line_chg;
	logic              mode_chg;
	logic              vb_nxt;
	logic              st_nxt;
	logic              ld_nxt;
	logic              fd_nxt;
	logic              in_xfer;

	logic              out_valid_q;
	lcd_mode_t         res_mode_q;
	logic [LINE_W-1:0] res_line_q;
	logic              res_coin_q;
	logic              res_vb_q;
	logic              res_st_q;
	logic              res_ld_q;
	logic              res_fd_q;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign in_xfer   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_compare_q <= '0;
			irq_coinc_q    <= 1'b0;
			irq_hblank_q   <= 1'b0;
			irq_vblank_q   <= 1'b0;
			irq_oam_q      <= 1'b0;
			double_speed_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_LINE_COMPARE: line_compare_q <= cfg_data;
				REG_IRQ_COINC:    irq_coinc_q    <= cfg_data[0];
				REG_IRQ_HBLANK:   irq_hblank_q   <= cfg_data[0];
				REG_IRQ_VBLANK:   irq_vblank_q   <= cfg_data[0];
				REG_IRQ_OAM:      irq_oam_q      <= cfg_data[0];
				REG_DOUBLE_SPEED: double_speed_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign dot_sum = dot_q + (double_speed_q ? STEP_DOUBLE : STEP_NORMAL);

	always_comb begin
		dot_nxt     = dot_q;
		mode_nxt    = mode_q;
		line_nxt    = line_q;
		coin_nxt    = coin_q;
		enabled_nxt = enabled_q;
		line_chg    = 1'b0;
		mode_chg    = 1'b0;
		vb_nxt      = 1'b0;
		st_nxt      = 1'b0;
		ld_nxt      = 1'b0;
		fd_nxt      = 1'b0;
		if (mode == ITEM_TOGGLE) begin
			dot_nxt  = '0;
			line_nxt = '0;
			if (lcd_on) begin
				mode_nxt    = MODE_HBLANK;
				coin_nxt    = 1'b0;
				enabled_nxt = 1'b1;
			end else begin
				enabled_nxt = 1'b0;
			end
		end else if (enabled_q) begin
			dot_nxt = dot_sum;
			case (mode_q)
				MODE_HBLANK: begin
					if (dot_sum >= DOTS_HBLANK) begin
						if (line_q == LAST_VISIBLE) begin
							mode_nxt = MODE_VBLANK;
							vb_nxt   = 1'b1;
							fd_nxt   = 1'b1;
						end else begin
							mode_nxt = MODE_OAM;
						end
						mode_chg = 1'b1;
						line_chg = 1'b1;
						line_nxt = line_q + 8'd1;
						dot_nxt  = dot_sum - DOTS_HBLANK;
					end
				end
				MODE_VBLANK: begin
					if (dot_sum >= DOTS_LINE) begin
						dot_nxt  = dot_sum - DOTS_LINE;
						line_chg = 1'b1;
						line_nxt = line_q + 8'd1;
						if (line_nxt > LAST_LINE) begin
							line_nxt = '0;
							mode_nxt = MODE_OAM;
						end
					end
				end
				MODE_OAM: begin
					if (dot_sum >= DOTS_OAM) begin
						dot_nxt  = dot_sum - DOTS_OAM;
						mode_nxt = MODE_XFER;
						mode_chg = 1'b1;
					end
				end
				default: begin
					if (dot_sum >= DOTS_TRANSFER) begin
						dot_nxt  = dot_sum - DOTS_TRANSFER;
						mode_nxt = MODE_HBLANK;
						mode_chg = 1'b1;
						ld_nxt   = 1'b1;
					end
				end
			endcase
			if (line_chg) begin
				coin_nxt = (line_nxt == line_compare_q);
				if (coin_nxt && irq_coinc_q) begin
					st_nxt = 1'b1;
				end
			end
			if (mode_chg) begin
				if ((mode_nxt == MODE_HBLANK && irq_hblank_q) ||
				    (mode_nxt == MODE_VBLANK && irq_vblank_q) ||
				    (mode_nxt == MODE_OAM && irq_oam_q)) begin
					st_nxt = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q     <= '0;
			mode_q    <= MODE_HBLANK;
			line_q    <= '0;
			coin_q    <= 1'b0;
			enabled_q <= 1'b0;
		end else if (in_xfer) begin
			dot_q     <= dot_nxt;
			mode_q    <= mode_nxt;
			line_q    <= line_nxt;
			coin_q    <= coin_nxt;
			enabled_q <= enabled_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			res_mode_q <= mode_nxt;
			res_line_q <= line_nxt;
			res_coin_q <= coin_nxt;
			res_vb_q   <= vb_nxt;
			res_st_q   <= st_nxt;
			res_ld_q   <= ld_nxt;
			res_fd_q   <= fd_nxt;
		end
	end

	assign out_valid    = out_valid_q;
	assign lcd_mode     = res_mode_q;
	assign current_line = res_line_q;
	assign coincidence  = res_coin_q;
	assign vblank_irq   = res_vb_q;
	assign stat_irq     = res_st_q;
	assign line_done    = res_ld_q;
	assign frame_done   = res_fd_q;

	`LMTS_ASSERT_IMP(a_line_range, 1'b1, line_q <= LAST_LINE)
	`LMTS_ASSERT_IMP(a_vblank_entry, out_valid_q && res_vb_q,
		res_mode_q == MODE_VBLANK && res_line_q == (LAST_VISIBLE + 8'd1) && res_fd_q)
	`LMTS_ASSERT_IMP(a_line_done_hblank, out_valid_q && res_ld_q, res_mode_q == MODE_HBLANK)
	`LMTS_ASSERT_NXT(a_toggle_clears, in_xfer && mode == ITEM_TOGGLE,
		line_q == '0 && dot_q == '0 && !res_st_q && !res_vb_q)
	`LMTS_ASSERT_NXT(a_result_held, out_valid_q && !out_ready,
		out_valid_q && $stable(res_line_q) && $stable(res_mode_q))

endmodule

// File: verif/lcd_timing_checker.sv
// Checker for the scanline timing sequencer: tracks registers, predicts each result and compares it.
`timescale 1ns / 100ps

module lcd_timing_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [2:0]                   cfg_index,
	input  logic [7:0]                   cfg_data,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic                         mode,
	input  logic                         lcd_on,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic [1:0]                   lcd_mode,
	input  logic [lcdmt_pkg::LINE_W-1:0] current_line,
	input  logic                         coincidence,
	input  logic                         vblank_irq,
	input  logic                         stat_irq,
	input  logic                         line_done,
	input  logic                         frame_done,
	output int                           outstanding,
	output int                           fail_count
);
	import lcdmt_pkg::*;

	typedef struct packed {
		lcd_mode_t         md;
		logic [LINE_W-1:0] line;
		logic              coinc;
		logic              vblank;
		logic              stat;
		logic              line_end;
		logic              frame_end;
	} scan_result_t;

	logic [LINE_W-1:0] cmp_line;
	logic              irq_coinc;
	logic              irq_hblank;
	logic              irq_vblank;
	logic              irq_oam;
	logic              dbl_speed;

	logic [DOT_W-1:0]  dots;
	lcd_mode_t         mode_q;
	logic [LINE_W-1:0] line_q;
	logic              coinc_q;
	logic              disp_on;

	scan_result_t      expected_q[$];
	int                fail_cnt = 0;

	task automatic advance_scanline(input logic toggle, input logic on, output scan_result_t res);
		logic line_moved;
		logic mode_moved;
		line_moved = 1'b0;
		mode_moved = 1'b0;
		res = '0;
		if (toggle) begin
			dots = '0;
			line_q = '0;
			if (on) begin
				mode_q = MODE_HBLANK;
				coinc_q = 1'b0;
				disp_on = 1'b1;
			end else begin
				disp_on = 1'b0;
			end
		end else if (disp_on) begin
			dots = dots + (dbl_speed ? STEP_DOUBLE : STEP_NORMAL);
			case (mode_q)
				MODE_HBLANK: begin
					if (dots >= DOTS_HBLANK) begin
						if (line_q == LAST_VISIBLE) begin
							mode_q = MODE_VBLANK;
							res.vblank = 1'b1;
							res.frame_end = 1'b1;
						end else begin
							mode_q = MODE_OAM;
						end
						mode_moved = 1'b1;
						line_moved = 1'b1;
						line_q = line_q + 1'b1;
						dots = dots - DOTS_HBLANK;
					end
				end
				MODE_VBLANK: begin
					if (dots >= DOTS_LINE) begin
						dots = dots - DOTS_LINE;
						line_moved = 1'b1;
						line_q = line_q + 1'b1;
						// Wrapping back to line 0 enters OAM scan without a mode interrupt.
						if (line_q > LAST_LINE) begin
							line_q = '0;
							mode_q = MODE_OAM;
						end
					end
				end
				MODE_OAM: begin
					if (dots >= DOTS_OAM) begin
						dots = dots - DOTS_OAM;
						mode_q = MODE_XFER;
						mode_moved = 1'b1;
					end
				end
				default: begin
					if (dots >= DOTS_TRANSFER) begin
						dots = dots - DOTS_TRANSFER;
						mode_q = MODE_HBLANK;
						mode_moved = 1'b1;
						res.line_end = 1'b1;
					end
				end
			endcase
			if (line_moved) begin
				coinc_q = (line_q == cmp_line);
				if (coinc_q && irq_coinc)
					res.stat = 1'b1;
			end
			if (mode_moved) begin
				if ((mode_q == MODE_HBLANK && irq_hblank) ||
				    (mode_q == MODE_VBLANK && irq_vblank) ||
				    (mode_q == MODE_OAM && irq_oam))
					res.stat = 1'b1;
			end
		end
		res.md = mode_q;
		res.line = line_q;
		res.coinc = coinc_q;
	endtask

	task automatic check_field(input string name, input int exp_val, input int act_val);
		if (exp_val != act_val) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, exp_val, act_val);
			fail_cnt++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		scan_result_t exp_res;
		if (!arst_n) begin
			cmp_line = '0;
			irq_coinc = 1'b0;
			irq_hblank = 1'b0;
			irq_vblank = 1'b0;
			irq_oam = 1'b0;
			dbl_speed = 1'b0;
			dots = '0;
			mode_q = MODE_HBLANK;
			line_q = '0;
			coinc_q = 1'b0;
			disp_on = 1'b0;
			expected_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_LINE_COMPARE: cmp_line = cfg_data;
					REG_IRQ_COINC:    irq_coinc = cfg_data[0];
					REG_IRQ_HBLANK:   irq_hblank = cfg_data[0];
					REG_IRQ_VBLANK:   irq_vblank = cfg_data[0];
					REG_IRQ_OAM:      irq_oam = cfg_data[0];
					REG_DOUBLE_SPEED: dbl_speed = cfg_data[0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t: result transfer with no expected value pending", $time);
					fail_cnt++;
				end else begin
					exp_res = expected_q.pop_front();
					check_field("lcd_mode", exp_res.md, lcd_mode);
					check_field("current_line", exp_res.line, current_line);
					check_field("coincidence", exp_res.coinc, coincidence);
					check_field("vblank_irq", exp_res.vblank, vblank_irq);
					check_field("stat_irq", exp_res.stat, stat_irq);
					check_field("line_done", exp_res.line_end, line_done);
					check_field("frame_done", exp_res.frame_end, frame_done);
				end
			end
			if (in_valid && in_ready) begin
				advance_scanline(mode == ITEM_TOGGLE, lcd_on, exp_res);
				expected_q.push_back(exp_res);
			end
		end
		outstanding <= expected_q.size();
		fail_count <= fail_cnt;
	end

endmodule

// File: verif/lcd_mode_timing_sequencer_tb.sv
// Testbench top for the scanline timing sequencer: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module lcd_mode_timing_sequencer_tb;
	import lcdmt_pkg::*;

	localparam int         HOLD_CYCLES    = 400;
	localparam int         WATCHDOG_LIMIT = 4000;
	localparam int         DRAIN_LIMIT    = 4000;
	localparam int         SETTLE_CYCLES  = 4;
	localparam logic [2:0] REG_SPARE_LO   = 3'd6;
	localparam logic [2:0] REG_SPARE_HI   = 3'd7;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [2:0]        cfg_index = '0;
	logic [7:0]        cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	item_kind_t        mode = ITEM_TICK;
	logic              lcd_on = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [1:0]        lcd_mode;
	logic [LINE_W-1:0] current_line;
	logic              coincidence;
	logic              vblank_irq;
	logic              stat_irq;
	logic              line_done;
	logic              frame_done;

	logic idle_en = 1'b1;
	logic hold_req = 1'b0;
	int   outstanding;
	int   fail_count;
	int   items_sent = 0;
	int   reg_writes = 0;
	int   frames_seen = 0;
	int   lines_seen = 0;
	int   quiet_cycles = 0;

	lcd_mode_timing_sequencer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.lcd_on(lcd_on),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.lcd_mode(lcd_mode),
		.current_line(current_line),
		.coincidence(coincidence),
		.vblank_irq(vblank_irq),
		.stat_irq(stat_irq),
		.line_done(line_done),
		.frame_done(frame_done)
	);

	lcd_timing_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.lcd_on(lcd_on),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.lcd_mode(lcd_mode),
		.current_line(current_line),
		.coincidence(coincidence),
		.vblank_irq(vblank_irq),
		.stat_irq(stat_irq),
		.line_done(line_done),
		.frame_done(frame_done),
		.outstanding(outstanding),
		.fail_count(fail_count)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		reg_writes++;
	endtask

	task automatic write_flag(input logic [2:0] idx, input logic flag);
		logic [7:0] data;
		data = 8'($urandom);
		data[0] = flag;
		write_reg(idx, data);
	endtask

	task automatic configure(input logic [7:0] cmp, input logic irq_c, input logic irq_h,
			input logic irq_v, input logic irq_o, input logic dbl);
		write_reg(REG_LINE_COMPARE, cmp);
		write_flag(REG_IRQ_COINC, irq_c);
		write_flag(REG_IRQ_HBLANK, irq_h);
		write_flag(REG_IRQ_VBLANK, irq_v);
		write_flag(REG_IRQ_OAM, irq_o);
		write_flag(REG_DOUBLE_SPEED, dbl);
		write_reg(REG_SPARE_LO, 8'($urandom));
		write_reg(REG_SPARE_HI, 8'($urandom));
		cfg_valid <= 1'b0;
	endtask

	task automatic send_item(input item_kind_t kind, input logic on);
		while (idle_en && $urandom_range(0, 99) < 25) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= kind;
		lcd_on <= on;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic run_items(input int count, input int toggle_per_mille);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 999) < toggle_per_mille)
				send_item(ITEM_TOGGLE, $urandom_range(0, 3) != 0);
			else
				send_item(ITEM_TICK, 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : receiver
		bit hold_done;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				out_ready <= !idle_en || $urandom_range(0, 99) >= 25;
			end
		end
	end

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			frames_seen += frame_done;
			lines_seen += line_done;
		end
		if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("lcd_mode_timing_sequencer: mismatch");
			$finish;
		end
	end

	initial begin : stimulus
		int waited;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		configure(8'd0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);

		// The display is off after reset; ticks must hold the state until it is switched on.
		send_item(ITEM_TICK, 1'b1);
		send_item(ITEM_TOGGLE, 1'b0);
		send_item(ITEM_TICK, 1'b0);
		send_item(ITEM_TOGGLE, 1'b1);
		send_item(ITEM_TOGGLE, 1'b1);
		repeat (20) send_item(ITEM_TICK, 1'($urandom_range(0, 1)));

		// A stretch at normal speed across the first few scanlines.
		run_items(250, 0);
		in_valid <= 1'b0;
		wait_drained();

		// A stretch at double speed with no idling on either side.
		configure(8'd1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1);
		idle_en <= 1'b0;
		send_item(ITEM_TOGGLE, 1'b1);
		run_items(150, 0);
		in_valid <= 1'b0;
		wait_drained();
		idle_en <= 1'b1;

		// Frequent toggles while the receiver holds off once for a long stretch.
		configure(8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
		hold_req <= 1'b1;
		run_items(200, 50);
		in_valid <= 1'b0;
		wait_drained();

		for (int p = 0; p < 3; p++) begin
			configure(8'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			send_item(ITEM_TOGGLE, 1'b1);
			run_items(25, 2);
			in_valid <= 1'b0;
			wait_drained();
		end

		waited = 0;
		while (outstanding != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (outstanding != 0) begin
			$display("lcd_mode_timing_sequencer: mismatch");
		end else begin
			repeat (SETTLE_CYCLES) @(posedge clk);
			$display("Sent %0d items and %0d register writes, normal and double speed.",
				items_sent, reg_writes);
			$display("Results marked %0d finished lines and %0d finished frames.",
				lines_seen, frames_seen);
			if (fail_count == 0)
				$display("lcd_mode_timing_sequencer: match");
			else
				$display("lcd_mode_timing_sequencer: mismatch");
		end
		$finish;
	end

endmodule

// File: filelist.f
+incdir+src
src/lcdmt_pkg.sv
src/lcd_mode_timing_sequencer.sv
verif/lcd_timing_checker.sv
verif/lcd_mode_timing_sequencer_tb.sv
